// ----- design/bridge_segment_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// bridge segment classifier assertion macros
// shared property forms for the classifier checks
// ----------------------------------------------------------------------------
`ifndef BRIDGE_SEGMENT_CLASSIFIER_DEFINES_SVH
`define BRIDGE_SEGMENT_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// constants and types of the bridge segment classifier
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    localparam int COORD_W = 32;
    localparam int LEN_W   = 31;
    localparam int SUM_W   = COORD_W + 1;     // doubled midpoint, spans
    localparam int OFS_W   = COORD_W + 2;     // doubled offsets from a vertex
    localparam int PROD_W  = OFS_W + SUM_W;   // cross products
    localparam int SQ_W    = 2 * LEN_W;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TEST  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        V_BRIDGE     = 2'd0,
        V_SUPPORTED  = 2'd1,
        V_SHORT      = 2'd2,
        V_NO_CONTOUR = 2'd3
    } t_verdict;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } t_seg;

endpackage

// ----- design/bridge_segment_classifier.sv -----
// ----------------------------------------------------------------------------
// bridge_segment_classifier
// stores a lower-layer contour and classifies current-layer segments as
// bridge, supported, too short or no contour by even-odd ray casting from the midpoint
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ----------------------------
//  in        in         i_in_valid / o_in_ready   i_opcode, i_start_x/y, i_end_x/y
//  out       out        o_out_valid / i_out_ready o_verdict, o_contour_overflowed
//  cfg       in         i_cfg_we                  i_cfg_data (min_bridge_length)
//
//  clear and load are done in the idle state; a test with an empty contour
//  goes straight to the result state, a too-short test passes the length states,
//  and a full test scans the contour memory read port, one segment per cycle
//  reset is synchronous, active low; it empties the contour and clears the
//  overflow flag and the length register; the memory itself is not cleared
//  one item is in work at a time; a finished verdict sits in the output
//  register, so the next item is taken while it waits for transfer
//
`include "bridge_segment_classifier_defines.svh"

module bridge_segment_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bsc_pkg::LEN_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_opcode,
    input  logic signed [bsc_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [bsc_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [bsc_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [bsc_pkg::COORD_W-1:0]  i_end_y,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_verdict,
    output logic                                o_contour_overflowed
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN_MAG,
        S_LEN_SQ,
        S_LEN_CMP,
        S_SCAN,
        S_RESULT
    } t_state;

    // control state
    t_state                        r_state;
    logic [bsc_pkg::CNT_W-1:0]     r_count;
    logic                          r_ovf;
    logic [bsc_pkg::LEN_W-1:0]     r_min_len;
    logic [bsc_pkg::CNT_W-1:0]     r_issue;
    logic                          r_v1, r_v2, r_v3;
    logic                          r_parity;
    bsc_pkg::t_verdict             r_pend;
    logic                          r_out_valid;
    logic [1:0]                    r_verdict;
    logic                          r_out_ovf;

    // datapath registers
    logic signed [bsc_pkg::SUM_W-1:0]  r_px2, r_py2;   // doubled midpoint
    logic signed [bsc_pkg::SUM_W-1:0]  r_dx, r_dy;     // test segment span
    logic [bsc_pkg::LEN_W-1:0]         r_ux, r_uy;
    logic                              r_big;
    logic [bsc_pkg::SQ_W-1:0]          r_sqx, r_sqy, r_sqm;

    // contour memory
    bsc_pkg::t_seg                     mem [bsc_pkg::MAX_SEGMENTS];
    bsc_pkg::t_seg                     r_rd_data;

    logic in_xfer;
    logic out_slot_free;
    logic mem_we;
    logic rd_en;
    logic scan_done;
    logic len_short;

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_xfer       = i_in_valid && o_in_ready;
    assign out_slot_free = !r_out_valid || i_out_ready;
    assign mem_we        = in_xfer && (i_opcode == bsc_pkg::OP_LOAD)
                           && (r_count < bsc_pkg::CNT_MAX);
    assign rd_en         = (r_state == S_SCAN) && (r_issue < r_count);
    assign scan_done     = (r_state == S_SCAN) && (r_issue == r_count)
                           && !r_v1 && !r_v2 && !r_v3;

    assign o_out_valid          = r_out_valid;
    assign o_verdict            = r_verdict;
    assign o_contour_overflowed = r_out_ovf;

    // ------------------------------------------------------------------
    // length check: magnitudes, squares, compare
    // ------------------------------------------------------------------
    logic [bsc_pkg::SUM_W-1:0] n_ux_full, n_uy_full;

    always_comb begin
        n_ux_full = r_dx[bsc_pkg::SUM_W-1] ? (~r_dx + 1'b1) : r_dx;
        n_uy_full = r_dy[bsc_pkg::SUM_W-1] ? (~r_dy + 1'b1) : r_dy;
        len_short = !r_big
                    && (({1'b0, r_sqx} + {1'b0, r_sqy}) < {1'b0, r_sqm});
    end

    // ------------------------------------------------------------------
    // crossing pipeline
    // stage 1: memory read data
    // stage 2: straddle test and vertex offsets
    // stage 3: cross products
    // stage 4: compare and parity toggle
    // ------------------------------------------------------------------
    logic signed [bsc_pkg::SUM_W-1:0]  n_ax2, n_ay2, n_by2, n_sdy, n_sdx;
    logic signed [bsc_pkg::OFS_W-1:0]  n_lhs_a, n_rhs_a;
    logic                              n_straddle;

    logic signed [bsc_pkg::OFS_W-1:0]  r2_lhs_a, r2_rhs_a;
    logic signed [bsc_pkg::SUM_W-1:0]  r2_sdy, r2_sdx;
    logic                              r2_straddle;

    logic signed [bsc_pkg::PROD_W-1:0] n3_lhs, n3_rhs;
    logic signed [bsc_pkg::PROD_W-1:0] r3_lhs, r3_rhs;
    logic                              r3_straddle, r3_dy_neg;
    logic                              n_cross;

    always_comb begin
        n_ax2   = {r_rd_data.ax, 1'b0};
        n_ay2   = {r_rd_data.ay, 1'b0};
        n_by2   = {r_rd_data.by, 1'b0};
        n_sdy   = bsc_pkg::SUM_W'(r_rd_data.by) - bsc_pkg::SUM_W'(r_rd_data.ay);
        n_sdx   = bsc_pkg::SUM_W'(r_rd_data.bx) - bsc_pkg::SUM_W'(r_rd_data.ax);
        n_lhs_a = bsc_pkg::OFS_W'(r_px2) - bsc_pkg::OFS_W'(n_ax2);
        n_rhs_a = bsc_pkg::OFS_W'(r_py2) - bsc_pkg::OFS_W'(n_ay2);
        // one end at or below the ray, the other strictly above
        n_straddle = ((n_ay2 <= r_py2) && (n_by2 > r_py2))
                     || ((n_by2 <= r_py2) && (n_ay2 > r_py2));
        n3_lhs  = r2_lhs_a * r2_sdy;
        n3_rhs  = r2_rhs_a * r2_sdx;
        // edge abscissa strictly right of the midpoint
        n_cross = r3_straddle && (r3_dy_neg ? (r3_lhs > r3_rhs) : (r3_lhs < r3_rhs));
    end

    // contour memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[bsc_pkg::IDX_W-1:0]] <= {i_start_x, i_start_y, i_end_x, i_end_y};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_issue[bsc_pkg::IDX_W-1:0]];
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_px2 <= bsc_pkg::SUM_W'(i_start_x) + bsc_pkg::SUM_W'(i_end_x);
            r_py2 <= bsc_pkg::SUM_W'(i_start_y) + bsc_pkg::SUM_W'(i_end_y);
            r_dx  <= bsc_pkg::SUM_W'(i_end_x) - bsc_pkg::SUM_W'(i_start_x);
            r_dy  <= bsc_pkg::SUM_W'(i_end_y) - bsc_pkg::SUM_W'(i_start_y);
        end
        if (r_state == S_LEN_MAG) begin
            r_ux  <= n_ux_full[bsc_pkg::LEN_W-1:0];
            r_uy  <= n_uy_full[bsc_pkg::LEN_W-1:0];
            r_big <= (|n_ux_full[bsc_pkg::SUM_W-1:bsc_pkg::LEN_W])
                     || (|n_uy_full[bsc_pkg::SUM_W-1:bsc_pkg::LEN_W]);
        end
        if (r_state == S_LEN_SQ) begin
            r_sqx <= r_ux * r_ux;
            r_sqy <= r_uy * r_uy;
            r_sqm <= r_min_len * r_min_len;
        end
        if (r_v1) begin
            r2_lhs_a    <= n_lhs_a;
            r2_rhs_a    <= n_rhs_a;
            r2_sdy      <= n_sdy;
            r2_sdx      <= n_sdx;
            r2_straddle <= n_straddle;
        end
        if (r_v2) begin
            r3_lhs      <= n3_lhs;
            r3_rhs      <= n3_rhs;
            r3_straddle <= r2_straddle;
            r3_dy_neg   <= r2_sdy[bsc_pkg::SUM_W-1];
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= '0;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_data;
        end
    end

    // sequencer, contour bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_issue     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_parity    <= 1'b0;
            r_pend      <= bsc_pkg::V_BRIDGE;
            r_out_valid <= 1'b0;
            r_verdict   <= '0;
            r_out_ovf   <= 1'b0;
        end else begin
            // the result state reloads the register itself when it frees
            if (r_out_valid && i_out_ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end

            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (rd_en) begin
                r_issue <= r_issue + 1'b1;
            end
            if (r_v3 && n_cross) begin
                r_parity <= ~r_parity;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_opcode)
                            bsc_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                            end
                            bsc_pkg::OP_LOAD: begin
                                if (r_count < bsc_pkg::CNT_MAX) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            bsc_pkg::OP_TEST: begin
                                if (r_count == '0) begin
                                    r_pend  <= bsc_pkg::V_NO_CONTOUR;
                                    r_state <= S_RESULT;
                                end else begin
                                    r_state <= S_LEN_MAG;
                                end
                            end
                            default: begin
                                // unused opcode: dropped
                            end
                        endcase
                    end
                end
                S_LEN_MAG: r_state <= S_LEN_SQ;
                S_LEN_SQ:  r_state <= S_LEN_CMP;
                S_LEN_CMP: begin
                    if (len_short) begin
                        r_pend  <= bsc_pkg::V_SHORT;
                        r_state <= S_RESULT;
                    end else begin
                        r_issue  <= '0;
                        r_parity <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_pend  <= r_parity ? bsc_pkg::V_SUPPORTED : bsc_pkg::V_BRIDGE;
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_verdict   <= r_pend;
                        r_out_ovf   <= r_ovf;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `BSC_ASSERT_IMP(a_count_in_range, 1'b1, r_count <= bsc_pkg::CNT_MAX, "contour count past capacity")
    `BSC_ASSERT_IMP(a_idle_pipe_empty, o_in_ready, !r_v1 && !r_v2 && !r_v3, "crossing pipe busy while idle")
    `BSC_ASSERT_NEXT(a_full_load_flags, in_xfer && (i_opcode == bsc_pkg::OP_LOAD) && (r_count == bsc_pkg::CNT_MAX), r_ovf && (r_count == bsc_pkg::CNT_MAX), "dropped load not flagged")
    `BSC_ASSERT_IMP(a_read_below_count, rd_en, r_issue < r_count, "read past stored contour")
    `BSC_ASSERT_NEXT(a_result_loads_output, (r_state == S_RESULT) && out_slot_free, r_out_valid && (r_state == S_IDLE), "verdict not registered")

endmodule
